// ===== rtl/dlb_pkg.sv =====
// Shared types and constants of the differential light balance step unit.
package dlb_pkg;

   localparam int LIGHT_W = 12;
   localparam int ANGLE_W = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 12;
   localparam int COUNT_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEADBAND = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT_DIRECTION = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_SIZE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_MIN = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_MAX = 3'd4;

   localparam logic [0:0] OP_TRACK = 1'b0;
   localparam logic [0:0] OP_CLEAR = 1'b1;

   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_POS = 2'd1;
   localparam logic [1:0] DIR_NEG = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_SAT = 3'd7;

   typedef struct packed {
      logic [0:0] opcode;
      logic [ANGLE_W-1:0] current_angle;
      logic [LIGHT_W-1:0] light_a;
      logic [LIGHT_W-1:0] light_b;
   } dlb_req_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] next_angle;
      logic balanced;
      logic finished;
      logic diverged;
   } dlb_rsp_type;

   typedef struct packed {
      logic [LIGHT_W-1:0] deadband;
      logic invert_direction;
      logic [ANGLE_W-1:0] step_size;
      logic [ANGLE_W-1:0] angle_min;
      logic [ANGLE_W-1:0] angle_max;
   } dlb_cfg_type;

endpackage

// ===== rtl/dlb_csr.sv =====
// Configuration register file of the differential light balance step unit.
module dlb_csr
   import dlb_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output dlb_cfg_type cfg
);

   dlb_cfg_type cfg_ff;
   dlb_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_DEADBAND: cfg_in.deadband = csr_data[LIGHT_W-1:0];
            CSR_INVERT_DIRECTION: cfg_in.invert_direction = csr_data[0];
            CSR_STEP_SIZE: cfg_in.step_size = csr_data[ANGLE_W-1:0];
            CSR_ANGLE_MIN: cfg_in.angle_min = csr_data[ANGLE_W-1:0];
            CSR_ANGLE_MAX: cfg_in.angle_max = csr_data[ANGLE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadband <= 12'd20;
         cfg_ff.invert_direction <= 1'b0;
         cfg_ff.step_size <= 8'd2;
         cfg_ff.angle_min <= 8'd0;
         cfg_ff.angle_max <= 8'd180;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/dlb_step.sv =====
// Tracking history registers and the combinational step decision logic.
module dlb_step
   import dlb_pkg::*;
#(
   parameter int GROW_LIMIT = 3,
   parameter int SENSOR_BITS = 12
) (
   input  logic clock,
   input  logic reset,
   input  logic fire,
   input  dlb_req_type item,
   input  dlb_cfg_type cfg,
   output dlb_rsp_type result
);

   localparam int USE_BITS = (SENSOR_BITS < LIGHT_W) ? SENSOR_BITS : LIGHT_W;
   localparam logic [LIGHT_W-1:0] SENSE_MASK = LIGHT_W'((32'd1 << USE_BITS) - 32'd1);
   localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(GROW_LIMIT);

   logic [1:0] last_dir_ff, last_dir_in;
   logic prev_valid_ff, prev_valid_in;
   logic [LIGHT_W-1:0] prev_mag_ff, prev_mag_in;
   logic [COUNT_W-1:0] grow_count_ff, grow_count_in;

   logic [LIGHT_W-1:0] light_a;
   logic [LIGHT_W-1:0] light_b;
   logic [LIGHT_W-1:0] mag;
   logic is_clear;
   logic bal;
   logic dir_pos;
   logic [1:0] dir;
   logic have_dir;
   logic reversed;
   logic growing;
   logic [COUNT_W-1:0] count_next;
   logic div;
   logic signed [ANGLE_W+1:0] cand;
   logic signed [ANGLE_W+1:0] clamped;
   logic at_limit;
   logic go;
   logic grow_on;
   logic div_hit;
   logic lim_hit;
   logic move;

   always_comb begin
      light_a = item.light_a & SENSE_MASK;
      light_b = item.light_b & SENSE_MASK;
      mag = (light_a >= light_b) ? (light_a - light_b) : (light_b - light_a);
      is_clear = (item.opcode == OP_CLEAR);
      bal = (mag <= cfg.deadband);
      dir_pos = (light_a > light_b) ^ cfg.invert_direction;
      dir = dir_pos ? DIR_POS : DIR_NEG;
      have_dir = (last_dir_ff != DIR_NONE);
      reversed = have_dir && (dir != last_dir_ff);
      growing = prev_valid_ff && (mag > prev_mag_ff);
      if (growing) begin
         count_next = (grow_count_ff != COUNT_SAT) ? grow_count_ff + 3'd1 : grow_count_ff;
      end else begin
         count_next = '0;
      end
      div = growing && (count_next >= LIMIT);

      if (dir_pos) begin
         cand = $signed({2'b00, item.current_angle}) + $signed({2'b00, cfg.step_size});
      end else begin
         cand = $signed({2'b00, item.current_angle}) - $signed({2'b00, cfg.step_size});
      end
      if (cand < $signed({2'b00, cfg.angle_min})) begin
         clamped = $signed({2'b00, cfg.angle_min});
      end else if (cand > $signed({2'b00, cfg.angle_max})) begin
         clamped = $signed({2'b00, cfg.angle_max});
      end else begin
         clamped = cand;
      end
      at_limit = (clamped == $signed({2'b00, item.current_angle}));

      go = !is_clear && !bal;
      grow_on = go && !reversed && have_dir;
      div_hit = grow_on && div;
      lim_hit = go && !reversed && !div_hit && at_limit;
      move = go && !reversed && !div_hit && !at_limit;

      result.next_angle = move ? clamped[ANGLE_W-1:0] : item.current_angle;
      result.balanced = !is_clear && bal;
      result.finished = (!is_clear && bal) || (go && reversed) || div_hit || lim_hit;
      result.diverged = div_hit;
   end

   always_comb begin
      last_dir_in = last_dir_ff;
      prev_valid_in = prev_valid_ff;
      prev_mag_in = prev_mag_ff;
      grow_count_in = grow_count_ff;
      if (fire) begin
         if (is_clear) begin
            last_dir_in = DIR_NONE;
            prev_valid_in = 1'b0;
            prev_mag_in = '0;
            grow_count_in = '0;
         end else begin
            if (grow_on) begin
               grow_count_in = count_next;
            end
            if (move) begin
               last_dir_in = dir;
               prev_valid_in = 1'b1;
               prev_mag_in = mag;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_dir_ff <= DIR_NONE;
         prev_valid_ff <= 1'b0;
         prev_mag_ff <= '0;
         grow_count_ff <= '0;
      end else begin
         last_dir_ff <= last_dir_in;
         prev_valid_ff <= prev_valid_in;
         prev_mag_ff <= prev_mag_in;
         grow_count_ff <= grow_count_in;
      end
   end

endmodule

// ===== rtl/differential_light_balance_step_unit.sv =====
// Top level of the differential light balance step unit with its input and result registers.
// The unit takes one tracking step per transfer: it compares two light samples against the
// deadband, derives a direction, checks for reversal, divergence and angle limits, and returns
// the next servo angle with balanced, finished and diverged flags; a clear item instead resets
// the tracking history and returns its angle with all flags low. An item enters an input
// register, is evaluated against the tracking history and lands in a result register, which
// holds it until it is taken. One item is taken in every cycle while the result register is
// free or being read; the history registers update as each item is evaluated, which sets
// that rate. Configuration writes are taken in every cycle and belong in idle periods.
module differential_light_balance_step_unit
   import dlb_pkg::*;
#(
   parameter int GROW_LIMIT = 3,
   parameter int SENSOR_BITS = 12
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  dlb_req_type req_payload,
   output logic rsp_valid,
   input  logic rsp_ready,
   output dlb_rsp_type rsp_payload,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   dlb_cfg_type cfg;
   dlb_rsp_type result;

   logic in_valid_ff, in_valid_in;
   dlb_req_type in_item_ff;
   logic out_valid_ff, out_valid_in;
   dlb_rsp_type out_item_ff;
   logic out_free;
   logic fire;

   assign csr_ready = 1'b1;

   dlb_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_valid && csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .cfg(cfg)
   );

   dlb_step #(
      .GROW_LIMIT(GROW_LIMIT),
      .SENSOR_BITS(SENSOR_BITS)
   ) u_step (
      .clock(clock),
      .reset(reset),
      .fire(fire),
      .item(in_item_ff),
      .cfg(cfg),
      .result(result)
   );

   assign out_free = !out_valid_ff || rsp_ready;
   assign fire = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_payload;
      end
      if (fire) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_item_ff;

   a_diverged_finishes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.diverged |-> rsp_payload.finished)
      else $error("A diverged result is not marked finished.");

   a_balanced_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.balanced |-> rsp_payload.finished && !rsp_payload.diverged)
      else $error("A balanced result carries inconsistent flags.");

   a_held_item_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_ready |=> in_valid_ff && $stable(in_item_ff))
      else $error("A waiting input item was lost during a result stall.");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("The input register is empty but no transfer is taken.");

   a_fire_fills_output: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("An evaluated item did not reach the result register.");

endmodule

// ===== sim/dlb_step_checker.sv =====
`timescale 1ns / 100ps
// Checker that predicts every result of the light balance step unit and compares it.
module dlb_step_checker
   import dlb_pkg::*;
#(
   parameter int GROW_LIMIT = 3,
   parameter int SENSOR_BITS = 12
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  dlb_req_type req_payload,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  dlb_rsp_type rsp_payload,
   input  logic csr_valid,
   input  logic csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int outstanding,
   output int mismatches
);

   dlb_cfg_type cfg;
   logic [1:0] last_dir;
   logic held_valid;
   logic [LIGHT_W-1:0] held_mag;
   logic [COUNT_W-1:0] grow_count;
   dlb_rsp_type expected_steps[$];
   int error_total = 0;

   function automatic dlb_rsp_type track_step(dlb_req_type item);
      dlb_rsp_type res;
      int light_a;
      int light_b;
      int mag;
      int cur;
      int target;
      logic [1:0] dir;
      light_a = int'(item.light_a) & ((1 << SENSOR_BITS) - 1);
      light_b = int'(item.light_b) & ((1 << SENSOR_BITS) - 1);
      cur = int'(item.current_angle);
      res.next_angle = item.current_angle;
      res.balanced = 1'b0;
      res.finished = 1'b0;
      res.diverged = 1'b0;
      if (item.opcode == OP_CLEAR) begin
         last_dir = DIR_NONE;
         held_valid = 1'b0;
         held_mag = '0;
         grow_count = '0;
         return res;
      end
      mag = (light_a >= light_b) ? light_a - light_b : light_b - light_a;
      if (mag <= int'(cfg.deadband)) begin
         res.balanced = 1'b1;
         res.finished = 1'b1;
         return res;
      end
      dir = (light_a > light_b) ? DIR_POS : DIR_NEG;
      if (cfg.invert_direction) dir = (dir == DIR_POS) ? DIR_NEG : DIR_POS;
      if (last_dir != DIR_NONE && dir != last_dir) begin
         res.finished = 1'b1;
         return res;
      end
      if (last_dir != DIR_NONE) begin
         if (held_valid && mag > int'(held_mag)) begin
            if (grow_count != COUNT_SAT) grow_count = grow_count + 1'b1;
            if (int'(grow_count) >= GROW_LIMIT) begin
               res.finished = 1'b1;
               res.diverged = 1'b1;
               return res;
            end
         end else begin
            grow_count = '0;
         end
      end
      if (dir == DIR_POS) target = cur + int'(cfg.step_size);
      else target = cur - int'(cfg.step_size);
      if (target < int'(cfg.angle_min)) target = int'(cfg.angle_min);
      else if (target > int'(cfg.angle_max)) target = int'(cfg.angle_max);
      if (target == cur) begin
         res.finished = 1'b1;
         return res;
      end
      last_dir = dir;
      held_mag = LIGHT_W'(mag);
      held_valid = 1'b1;
      res.next_angle = ANGLE_W'(target);
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      dlb_rsp_type want;
      if (reset) begin
         cfg = '{deadband: 12'd20, invert_direction: 1'b0, step_size: 8'd2,
                 angle_min: 8'd0, angle_max: 8'd180};
         last_dir = DIR_NONE;
         held_valid = 1'b0;
         held_mag = '0;
         grow_count = '0;
         expected_steps.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEADBAND: cfg.deadband = csr_data[LIGHT_W-1:0];
               CSR_INVERT_DIRECTION: cfg.invert_direction = csr_data[0];
               CSR_STEP_SIZE: cfg.step_size = csr_data[ANGLE_W-1:0];
               CSR_ANGLE_MIN: cfg.angle_min = csr_data[ANGLE_W-1:0];
               CSR_ANGLE_MAX: cfg.angle_max = csr_data[ANGLE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_steps.size() == 0) begin
               $error("result transfer with no result expected");
               error_total++;
            end else begin
               want = expected_steps.pop_front();
               if (rsp_payload.next_angle !== want.next_angle) begin
                  $error("next_angle: expected %0d, actual %0d",
                         want.next_angle, rsp_payload.next_angle);
                  error_total++;
               end
               if (rsp_payload.balanced !== want.balanced) begin
                  $error("balanced: expected %0b, actual %0b",
                         want.balanced, rsp_payload.balanced);
                  error_total++;
               end
               if (rsp_payload.finished !== want.finished) begin
                  $error("finished: expected %0b, actual %0b",
                         want.finished, rsp_payload.finished);
                  error_total++;
               end
               if (rsp_payload.diverged !== want.diverged) begin
                  $error("diverged: expected %0b, actual %0b",
                         want.diverged, rsp_payload.diverged);
                  error_total++;
               end
            end
         end
         if (req_valid && req_ready) expected_steps.push_back(track_step(req_payload));
      end
      outstanding <= expected_steps.size();
      mismatches <= error_total;
   end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Testbench top for the step unit: clock, reset, stimulus, receiver stalls and the verdict.
module testbench;
   import dlb_pkg::*;

   localparam int GROW_LIMIT = 3;
   localparam int SENSOR_BITS = 12;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   dlb_req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   dlb_rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int outstanding;
   int mismatches;

   dlb_cfg_type cfg;
   bit hold_request = 1'b0;
   int run_mag = 100;
   bit run_neg = 1'b0;

   differential_light_balance_step_unit #(
      .GROW_LIMIT(GROW_LIMIT),
      .SENSOR_BITS(SENSOR_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   dlb_step_checker #(
      .GROW_LIMIT(GROW_LIMIT),
      .SENSOR_BITS(SENSOR_BITS)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .outstanding(outstanding),
      .mismatches(mismatches)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("FAILURE");
      $finish;
   end

   initial begin : receiver
      int hold_left;
      int mode_left;
      int stall_pct;
      hold_left = 0;
      mode_left = 0;
      stall_pct = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 60;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode_left = $urandom_range(10, 80);
               case ($urandom_range(0, 4))
                  0, 1: stall_pct = 0;
                  2: stall_pct = 25;
                  3: stall_pct = 50;
                  default: stall_pct = 85;
               endcase
            end
            mode_left--;
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   function automatic dlb_req_type step_req(logic [0:0] op, logic [ANGLE_W-1:0] angle,
                                            logic [LIGHT_W-1:0] a, logic [LIGHT_W-1:0] b);
      dlb_req_type item;
      item.opcode = op;
      item.current_angle = angle;
      item.light_a = a;
      item.light_b = b;
      return item;
   endfunction

   function automatic dlb_req_type make_item();
      dlb_req_type item;
      int roll;
      int lo;
      int base;
      int step;
      roll = $urandom_range(0, 99);
      step = int'(cfg.step_size);
      item.opcode = OP_TRACK;
      case ($urandom_range(0, 9))
         0, 1: item.current_angle =
            ANGLE_W'(int'(cfg.angle_min) + int'($urandom_range(0, 2 * step)) - step);
         2, 3: item.current_angle =
            ANGLE_W'(int'(cfg.angle_max) + int'($urandom_range(0, 2 * step)) - step);
         4: item.current_angle = ANGLE_W'($urandom);
         default: item.current_angle = ANGLE_W'($urandom_range(0, 180));
      endcase
      item.light_a = LIGHT_W'($urandom);
      item.light_b = LIGHT_W'($urandom);
      if (roll < 7) begin
         item.opcode = OP_CLEAR;
         run_mag = 0;
      end else if (roll < 17) begin
         item.opcode = 1'($urandom);
      end else if (roll < 25) begin
         lo = int'(cfg.deadband) + int'($urandom_range(0, 2)) - 1;
         if (lo < 0) lo = 0;
         if (lo > 4095) lo = 4095;
         base = $urandom_range(0, 4095 - lo);
         item.light_a = LIGHT_W'(base + lo);
         item.light_b = LIGHT_W'(base);
         if ($urandom_range(0, 1)) begin
            item.light_a = LIGHT_W'(base);
            item.light_b = LIGHT_W'(base + lo);
         end
      end else begin
         if ($urandom_range(0, 11) == 0) run_neg = !run_neg;
         lo = int'(cfg.deadband) + 1;
         if (lo > 4095) lo = 4095;
         if ($urandom_range(0, 99) < 65) run_mag = run_mag + int'($urandom_range(1, 200));
         else run_mag = run_mag - int'($urandom_range(0, 200));
         if (run_mag < lo) run_mag = lo + int'($urandom_range(0, 50));
         if (run_mag > 4095) run_mag = lo;
         base = $urandom_range(0, 4095 - run_mag);
         if (run_neg) begin
            item.light_a = LIGHT_W'(base);
            item.light_b = LIGHT_W'(base + run_mag);
         end else begin
            item.light_a = LIGHT_W'(base + run_mag);
            item.light_b = LIGHT_W'(base);
         end
      end
      return item;
   endfunction

   task automatic send_item(input dlb_req_type item);
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input dlb_cfg_type c, input int count, input bit with_hold);
      int burst_left;
      drain();
      cfg = c;
      write_csr(CSR_DEADBAND, c.deadband);
      write_csr(CSR_INVERT_DIRECTION, CSR_DATA_W'(c.invert_direction) |
                (CSR_DATA_W'($urandom) & 12'hFFE));
      write_csr(CSR_STEP_SIZE, CSR_DATA_W'(c.step_size) | (CSR_DATA_W'($urandom) & 12'hF00));
      write_csr(CSR_ANGLE_MIN, CSR_DATA_W'(c.angle_min) | (CSR_DATA_W'($urandom) & 12'hF00));
      write_csr(CSR_ANGLE_MAX, CSR_DATA_W'(c.angle_max) | (CSR_DATA_W'($urandom) & 12'hF00));
      write_csr(CSR_INDEX_W'($urandom_range(int'(CSR_ANGLE_MAX) + 1, (1 << CSR_INDEX_W) - 1)),
                CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      burst_left = 0;
      if (with_hold) begin
         hold_request = 1'b1;
         burst_left = 40;
      end
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
            burst_left = $urandom_range(1, 30);
         end
         burst_left--;
         send_item(make_item());
      end
   endtask

   initial begin : stimulus
      dlb_cfg_type c;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      cfg = '{deadband: 12'd20, invert_direction: 1'b0, step_size: 8'd2,
              angle_min: 8'd0, angle_max: 8'd180};

      send_item(step_req(OP_TRACK, 8'd90, 12'd0, 12'd0));
      send_item(step_req(OP_TRACK, 8'd90, 12'd4095, 12'd4095));
      send_item(step_req(OP_TRACK, 8'd90, 12'd20, 12'd0));
      send_item(step_req(OP_TRACK, 8'd90, 12'd4095, 12'd0));
      send_item(step_req(OP_TRACK, 8'd92, 12'd0, 12'd4095));
      send_item(step_req(OP_CLEAR, 8'd255, 12'd4095, 12'd4095));
      // A steadily growing error diverges and then saturates the growth count.
      for (int k = 1; k <= 9; k++) begin
         send_item(step_req(OP_TRACK, 8'd100, LIGHT_W'(100 * k), 12'd0));
      end
      send_item(step_req(OP_TRACK, 8'd100, 12'd21, 12'd0));
      send_item(step_req(OP_CLEAR, 8'd0, 12'd0, 12'd0));
      send_item(step_req(OP_TRACK, 8'd179, 12'd4095, 12'd0));
      send_item(step_req(OP_TRACK, 8'd180, 12'd4095, 12'd0));
      send_item(step_req(OP_CLEAR, 8'd180, 12'd0, 12'd0));
      send_item(step_req(OP_TRACK, 8'd0, 12'd0, 12'd4095));
      send_item(step_req(OP_TRACK, 8'd255, 12'd1000, 12'd0));

      run_phase('{12'd0, 1'b1, 8'd180, 8'd0, 8'd180}, 60, 1'b0);
      run_phase('{12'd4095, 1'b0, 8'd0, 8'd180, 8'd180}, 15, 1'b0);
      run_phase('{12'd15, 1'b0, 8'd3, 8'd30, 8'd150}, 60, 1'b1);
      run_phase('{12'd10, 1'b1, 8'd5, 8'd120, 8'd60}, 50, 1'b0);
      run_phase('{12'd0, 1'b0, 8'd1, 8'd0, 8'd0}, 30, 1'b0);
      for (int p = 0; p < 5; p++) begin
         c.deadband = LIGHT_W'($urandom_range(0, 300));
         c.invert_direction = 1'($urandom);
         c.step_size = ($urandom_range(0, 3) == 0) ? ANGLE_W'($urandom_range(0, 180))
                                                   : ANGLE_W'($urandom_range(1, 12));
         c.angle_min = ANGLE_W'($urandom_range(0, 90));
         c.angle_max = ANGLE_W'($urandom_range(int'(c.angle_min), 180));
         run_phase(c, 60, 1'b0);
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/dlb_pkg.sv
rtl/dlb_csr.sv
rtl/dlb_step.sv
rtl/differential_light_balance_step_unit.sv
sim/dlb_step_checker.sv
sim/testbench.sv
